FILE: src/pfb_pkg.sv
package pfb_pkg;

   // default store geometry
   localparam int COLUMNS_DEF = 84;
   localparam int PAGES_DEF   = 6;

   // request actions
   typedef enum logic [1:0] {
      ACT_PLOT  = 2'd0,
      ACT_BLIT  = 2'd1,
      ACT_CLEAR = 2'd2,
      ACT_READ  = 2'd3
   } action_type;

   // plot modes
   localparam logic [1:0] MODE_CLEAR  = 2'd0;
   localparam logic [1:0] MODE_SET    = 2'd1;
   localparam logic [1:0] MODE_INVERT = 2'd2;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADDR,
      ST_READ,
      ST_WRITE,
      ST_NEXT_READ,
      ST_NEXT_WRITE,
      ST_SWEEP
   } state_type;

endpackage

FILE: src/page_framebuffer_plot_blit_core.sv
// channel   ports                                   handshake
// request   req_action .. req_glyph_height          start high while busy low
// response  rsp_pixel_byte, rsp_out_column,         rsp_strobe, one cycle
//           rsp_out_page
//
// plot, read and blit pass address multiply, registered read, then modify and
// write back (a read registers its result instead), all through the single
// store port; a blit whose carry spills into the next page adds a read and a
// merge there; clear sweeps the store one byte a cycle, COLUMNS*PAGES bytes
// (504 default); reset starts the same sweep; busy stays high until it ends
// a read result shows in the cycle after the write-back step; it cannot be held
module page_framebuffer_plot_blit_core #(
   parameter int COLUMNS = pfb_pkg::COLUMNS_DEF,
   parameter int PAGES   = pfb_pkg::PAGES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_action,
   input  logic [6:0] req_column,
   input  logic [5:0] req_pixel_row,
   input  logic [1:0] req_plot_mode,
   input  logic [7:0] req_glyph_byte,
   input  logic [2:0] req_byte_index,
   input  logic       req_last_byte,
   input  logic [5:0] req_glyph_height,
   output logic       rsp_strobe,
   output logic [7:0] rsp_pixel_byte,
   output logic [6:0] rsp_out_column,
   output logic [2:0] rsp_out_page
);
   import pfb_pkg::*;

   localparam int DEPTH  = COLUMNS * PAGES;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CALC_W = ADDR_W + 6;

   // frame store
   logic [7:0] mem [DEPTH];
   logic [7:0] rdata_ff;
   logic       mem_we;
   logic [7:0] mem_wdata;

   // control registers
   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [7:0]        carry_ff, carry_in;
   logic              strobe_ff, strobe_in;
   logic              ok_ff, ok_in;

   // latched request
   action_type act_ff, act_in;
   logic [6:0] col_ff, col_in;
   logic [5:0] row_ff, row_in;
   logic [1:0] mode_ff, mode_in;
   logic [7:0] glyph_ff, glyph_in;
   logic [2:0] bidx_ff, bidx_in;
   logic       last_ff, last_in;
   logic [2:0] hgt_ff, hgt_in;

   // response registers
   logic [7:0] pbyte_ff, pbyte_in;
   logic [6:0] ocol_ff, ocol_in;
   logic [2:0] opage_ff, opage_in;

   // datapath helpers
   logic [2:0]        page;
   logic [2:0]        off;
   logic [4:0]        pg;
   logic [4:0]        tgt;
   logic              col_ok;
   logic              tgt_ok;
   logic              next_ok;
   logic [CALC_W-1:0] addr_calc;
   logic [15:0]       shifted;
   logic [7:0]        bit_mask;
   logic [7:0]        kept;
   logic [2:0]        low_n;
   logic [7:0]        low_mask;

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_strobe     = strobe_ff;
   assign rsp_pixel_byte = pbyte_ff;
   assign rsp_out_column = ocol_ff;
   assign rsp_out_page   = opage_ff;

   // address and merge arithmetic
   always_comb begin
      page      = row_ff[5:3];
      off       = row_ff[2:0];
      pg        = {2'b00, page} + {2'b00, bidx_ff};
      tgt       = (act_ff == ACT_BLIT) ? pg : {2'b00, page};
      col_ok    = {3'b000, col_ff} < 10'(COLUMNS);
      tgt_ok    = col_ok && ({1'b0, tgt} < 6'(PAGES));
      next_ok   = col_ok && (({1'b0, pg} + 6'd1) < 6'(PAGES));
      addr_calc = CALC_W'(tgt) * CALC_W'(COLUMNS) + CALC_W'(col_ff);
      shifted   = {8'h00, glyph_ff} << off;
      bit_mask  = 8'h01 << off;
      if (bidx_ff == 3'd0) begin
         kept = (ok_ff ? rdata_ff : 8'h00) & ((8'h01 << off) - 8'h01);
      end else begin
         kept = carry_ff;
      end
      low_n    = off + hgt_ff;
      low_mask = (8'h01 << low_n) - 8'h01;
   end

   // sequencer next state and outputs
   always_comb begin
      state_in  = state_ff;
      addr_in   = addr_ff;
      carry_in  = carry_ff;
      strobe_in = 1'b0;
      ok_in     = ok_ff;
      act_in    = act_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      mode_in   = mode_ff;
      glyph_in  = glyph_ff;
      bidx_in   = bidx_ff;
      last_in   = last_ff;
      hgt_in    = hgt_ff;
      pbyte_in  = pbyte_ff;
      ocol_in   = ocol_ff;
      opage_in  = opage_ff;
      mem_we    = 1'b0;
      mem_wdata = 8'h00;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               act_in   = action_type'(req_action);
               col_in   = req_column;
               row_in   = req_pixel_row;
               mode_in  = req_plot_mode;
               glyph_in = req_glyph_byte;
               bidx_in  = req_byte_index;
               last_in  = req_last_byte;
               hgt_in   = req_glyph_height[2:0];
               if (action_type'(req_action) == ACT_CLEAR) begin
                  addr_in  = '0;
                  state_in = ST_SWEEP;
               end else begin
                  state_in = ST_ADDR;
               end
            end
         end
         ST_ADDR: begin
            addr_in  = addr_calc[ADDR_W-1:0];
            ok_in    = tgt_ok;
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            state_in = ST_IDLE;
            case (act_ff)
               ACT_PLOT: begin
                  mem_we = ok_ff;
                  case (mode_ff)
                     MODE_CLEAR:  mem_wdata = rdata_ff & ~bit_mask;
                     MODE_SET:    mem_wdata = rdata_ff | bit_mask;
                     MODE_INVERT: mem_wdata = rdata_ff ^ bit_mask;
                     default:     mem_wdata = rdata_ff;
                  endcase
               end
               ACT_BLIT: begin
                  mem_we    = ok_ff;
                  mem_wdata = kept | shifted[7:0];
                  carry_in  = shifted[15:8];
                  if (last_ff && (off != 3'd0) && next_ok) begin
                     addr_in  = addr_ff + ADDR_W'(COLUMNS);
                     state_in = ST_NEXT_READ;
                  end
               end
               ACT_READ: begin
                  strobe_in = ok_ff;
                  pbyte_in  = rdata_ff;
                  ocol_in   = col_ff;
                  opage_in  = page;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_NEXT_READ: begin
            state_in = ST_NEXT_WRITE;
         end
         ST_NEXT_WRITE: begin
            mem_we    = 1'b1;
            mem_wdata = carry_ff | (rdata_ff & ~low_mask);
            state_in  = ST_IDLE;
         end
         ST_SWEEP: begin
            mem_we    = 1'b1;
            mem_wdata = 8'h00;
            if (addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + ADDR_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_SWEEP;
         addr_ff   <= '0;
         carry_ff  <= 8'h00;
         strobe_ff <= 1'b0;
         ok_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         addr_ff   <= addr_in;
         carry_ff  <= carry_in;
         strobe_ff <= strobe_in;
         ok_ff     <= ok_in;
      end
   end

   // request and response payload
   always_ff @(posedge clock) begin
      act_ff   <= act_in;
      col_ff   <= col_in;
      row_ff   <= row_in;
      mode_ff  <= mode_in;
      glyph_ff <= glyph_in;
      bidx_ff  <= bidx_in;
      last_ff  <= last_in;
      hgt_ff   <= hgt_in;
      pbyte_ff <= pbyte_in;
      ocol_ff  <= ocol_in;
      opage_ff <= opage_in;
   end

   // store port: one write, one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr_ff] <= mem_wdata;
      end
      rdata_ff <= mem[addr_ff];
   end

   // a response only follows the write-back step of a read
   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> ($past(state_ff) == ST_WRITE && $past(act_ff) == ACT_READ))
      else $error("response strobe without a read request");

   // a response leaves the sequencer idle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> !busy)
      else $error("response strobe while busy");

   // next-page merge always follows its own read
   a_next_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NEXT_WRITE) |-> ($past(state_ff) == ST_NEXT_READ))
      else $error("carry merge without read");

   // clearing sweep stays inside the store
   a_sweep_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (32'(addr_ff) < DEPTH))
      else $error("sweep address out of range");

endmodule

FILE: sim/tb.sv
module tb;
   import pfb_pkg::*;

   localparam int COLS = COLUMNS_DEF;
   localparam int PGS = PAGES_DEF;
   localparam int ROWS = PGS * 8;
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 16;
   localparam int MAX_PRINTS = 20;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      action_type action;
      logic [6:0] column;
      logic [5:0] pixel_row;
      logic [1:0] plot_mode;
      logic [7:0] glyph_byte;
      logic [2:0] byte_index;
      logic       last_byte;
      logic [5:0] glyph_height;
   } fb_request_t;

   typedef struct packed {
      logic [7:0] pixel_byte;
      logic [6:0] column;
      logic [2:0] page;
   } read_result_t;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [1:0] req_action = '0;
   logic [6:0] req_column = '0;
   logic [5:0] req_pixel_row = '0;
   logic [1:0] req_plot_mode = '0;
   logic [7:0] req_glyph_byte = '0;
   logic [2:0] req_byte_index = '0;
   logic       req_last_byte = 1'b0;
   logic [5:0] req_glyph_height = '0;
   logic       rsp_strobe;
   logic [7:0] rsp_pixel_byte;
   logic [6:0] rsp_out_column;
   logic [2:0] rsp_out_page;

   // shadow copy of the display store and the blit carry
   logic [7:0] shadow_frame [COLS*PGS];
   logic [7:0] shadow_carry;

   fb_request_t  pending_requests [$];
   read_result_t expected_reads [$];
   fb_request_t  drive_req;
   read_result_t want;
   int queued_count = 0;
   int counted_items = 0;
   int accepted_count = 0;
   int mismatch_count = 0;
   int stall_cycles = 0;

   page_framebuffer_plot_blit_core DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_action(req_action),
      .req_column(req_column),
      .req_pixel_row(req_pixel_row),
      .req_plot_mode(req_plot_mode),
      .req_glyph_byte(req_glyph_byte),
      .req_byte_index(req_byte_index),
      .req_last_byte(req_last_byte),
      .req_glyph_height(req_glyph_height),
      .rsp_strobe(rsp_strobe),
      .rsp_pixel_byte(rsp_pixel_byte),
      .rsp_out_column(rsp_out_column),
      .rsp_out_page(rsp_out_page)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTS)
         $display("mismatch at %0t: %s", $time, what);
   endtask

   function automatic bit cell_valid(input int col, input int page);
      return col < COLS && page < PGS;
   endfunction

   // apply one accepted request to the shadow store, queue any read data
   task automatic update_shadow_frame(input fb_request_t rq);
      int page;
      int off;
      int pg;
      int addr;
      int n;
      logic [7:0] bit_mask;
      logic [7:0] kept;
      logic [7:0] low_mask;
      logic [15:0] shifted;
      page = rq.pixel_row >> 3;
      off = rq.pixel_row[2:0];
      case (rq.action)
         ACT_PLOT: begin
            if (cell_valid(rq.column, page)) begin
               addr = page * COLS + rq.column;
               bit_mask = 8'h01 << off;
               case (rq.plot_mode)
                  MODE_CLEAR:  shadow_frame[addr] = shadow_frame[addr] & ~bit_mask;
                  MODE_SET:    shadow_frame[addr] = shadow_frame[addr] | bit_mask;
                  MODE_INVERT: shadow_frame[addr] = shadow_frame[addr] ^ bit_mask;
                  default: ;
               endcase
            end
         end
         ACT_BLIT: begin
            pg = page + rq.byte_index;
            addr = pg * COLS + rq.column;
            // top byte keeps the pixels above the glyph, later bytes take the carry
            if (rq.byte_index == 3'd0) begin
               kept = cell_valid(rq.column, pg) ? shadow_frame[addr] : 8'h00;
               kept = kept & ((8'h01 << off) - 8'h01);
            end else begin
               kept = shadow_carry;
            end
            shifted = 16'(rq.glyph_byte) << off;
            if (cell_valid(rq.column, pg))
               shadow_frame[addr] = kept | shifted[7:0];
            shadow_carry = shifted[15:8];
            // spill of the last byte into the page below
            if (rq.last_byte && off != 0 && cell_valid(rq.column, pg + 1)) begin
               addr = (pg + 1) * COLS + rq.column;
               n = (off + rq.glyph_height) % 8;
               low_mask = (8'h01 << n) - 8'h01;
               shadow_frame[addr] = shadow_carry | (shadow_frame[addr] & ~low_mask);
            end
         end
         ACT_CLEAR: begin
            foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
         end
         default: begin
            if (cell_valid(rq.column, page))
               expected_reads.push_back('{pixel_byte: shadow_frame[page * COLS + rq.column],
                                          column: rq.column, page: 3'(page)});
         end
      endcase
   endtask

   task automatic queue_request(input action_type act, input int col, input int row,
                                input logic [1:0] mode, input logic [7:0] glyph,
                                input int bidx, input bit last, input int height);
      fb_request_t rq;
      rq.action = act;
      rq.column = 7'(col);
      rq.pixel_row = 6'(row);
      rq.plot_mode = mode;
      rq.glyph_byte = glyph;
      rq.byte_index = 3'(bidx);
      rq.last_byte = last;
      rq.glyph_height = 6'(height);
      pending_requests.push_back(rq);
      queued_count++;
      // plots and reads the block simply drops are not counted
      if (act == ACT_BLIT || act == ACT_CLEAR || cell_valid(rq.column, rq.pixel_row >> 3))
         counted_items++;
   endtask

   task automatic queue_read(input int col, input int row);
      queue_request(ACT_READ, col, row, 2'($urandom), 8'($urandom), $urandom_range(7),
                    1'($urandom), $urandom_range(63));
   endtask

   // one glyph column written top to bottom, then read back
   task automatic queue_glyph_column();
      int col;
      int row;
      int height;
      int nbytes;
      col = $urandom_range(COLS - 1);
      row = $urandom_range(ROWS - 1);
      height = ($urandom_range(3) == 0) ? $urandom_range(1, 48) : $urandom_range(1, 16);
      nbytes = (height + 7) / 8;
      for (int b = 0; b < nbytes; b++)
         queue_request(ACT_BLIT, col, row, 2'($urandom), 8'($urandom), b, b == nbytes - 1,
                       height);
      for (int p = row / 8; p <= row / 8 + nbytes && p < PGS; p++)
         queue_read(col, p * 8 + $urandom_range(7));
   endtask

   // anything the ports allow, clear kept rare since it sweeps the store
   task automatic queue_noise();
      action_type act;
      act = action_type'($urandom_range(3));
      if (act == ACT_CLEAR && $urandom_range(9) != 0)
         act = ACT_READ;
      queue_request(act, $urandom_range(127), $urandom_range(63), 2'($urandom), 8'($urandom),
                    $urandom_range(7), 1'($urandom), $urandom_range(63));
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            update_shadow_frame(drive_req);
            accepted_count = accepted_count + 1;
         end
         if (!(start && busy)) begin
            if (pending_requests.size() != 0 &&
                !((accepted_count < 260 || accepted_count >= 380) &&
                  $urandom_range(99) < 28)) begin
               drive_req = pending_requests.pop_front();
               start <= 1'b1;
               req_action <= drive_req.action;
               req_column <= drive_req.column;
               req_pixel_row <= drive_req.pixel_row;
               req_plot_mode <= drive_req.plot_mode;
               req_glyph_byte <= drive_req.glyph_byte;
               req_byte_index <= drive_req.byte_index;
               req_last_byte <= drive_req.last_byte;
               req_glyph_height <= drive_req.glyph_height;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // read data monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_reads.size() == 0) begin
            report_mismatch($sformatf("unexpected read data %02h col %0d page %0d",
                                      rsp_pixel_byte, rsp_out_column, rsp_out_page));
         end else begin
            want = expected_reads.pop_front();
            if (rsp_pixel_byte !== want.pixel_byte)
               report_mismatch($sformatf("pixel_byte %02h, want %02h (col %0d page %0d)",
                                         rsp_pixel_byte, want.pixel_byte, want.column,
                                         want.page));
            if (rsp_out_column !== want.column)
               report_mismatch($sformatf("out_column %0d, want %0d",
                                         rsp_out_column, want.column));
            if (rsp_out_page !== want.page)
               report_mismatch($sformatf("out_page %0d, want %0d", rsp_out_page, want.page));
         end
      end
   end

   // watchdog on cycles with no request and no read data
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
      shadow_carry = 8'h00;

      // directed: corners, every mode, out of range, blit carry and spill, clear
      queue_read(0, 0);
      queue_read(COLS - 1, ROWS - 1);
      queue_request(ACT_PLOT, 0, 0, MODE_SET, 8'h00, 0, 1'b0, 1);
      queue_request(ACT_PLOT, COLS - 1, ROWS - 1, MODE_SET, 8'hff, 7, 1'b1, 63);
      queue_request(ACT_PLOT, COLS - 1, ROWS - 1, MODE_INVERT, 8'h00, 0, 1'b0, 0);
      queue_request(ACT_PLOT, COLS - 1, ROWS - 2, MODE_INVERT, 8'h00, 0, 1'b0, 0);
      queue_request(ACT_PLOT, 0, 0, MODE_UNUSED, 8'h00, 0, 1'b0, 0);
      queue_request(ACT_PLOT, 1, 9, MODE_SET, 8'h00, 0, 1'b0, 0);
      queue_request(ACT_PLOT, 1, 9, MODE_CLEAR, 8'h00, 0, 1'b0, 0);
      queue_request(ACT_PLOT, COLS, 0, MODE_SET, 8'h00, 0, 1'b0, 0);
      queue_request(ACT_PLOT, 127, 63, MODE_SET, 8'h00, 0, 1'b0, 0);
      queue_request(ACT_PLOT, 0, ROWS, MODE_SET, 8'h00, 0, 1'b0, 0);
      queue_read(0, 0);
      queue_read(COLS - 1, 40);
      queue_read(1, 9);
      queue_request(ACT_BLIT, 10, 13, MODE_CLEAR, 8'hff, 0, 1'b0, 12);
      queue_request(ACT_BLIT, 10, 13, MODE_CLEAR, 8'h0f, 1, 1'b1, 12);
      queue_read(10, 8);
      queue_read(10, 16);
      queue_read(10, 24);
      queue_request(ACT_BLIT, 20, 0, MODE_CLEAR, 8'ha5, 2, 1'b1, 1);
      queue_request(ACT_BLIT, 100, 5, MODE_CLEAR, 8'hff, 0, 1'b1, 48);
      queue_request(ACT_BLIT, 30, 45, MODE_CLEAR, 8'hc3, 0, 1'b1, 3);
      queue_request(ACT_BLIT, 31, 6, MODE_CLEAR, 8'h81, 0, 1'b1, 48);
      queue_read(COLS, 0);
      queue_read(0, 63);
      queue_read(20, 16);
      queue_read(30, 40);
      queue_read(31, 8);
      queue_request(ACT_CLEAR, 0, 0, MODE_CLEAR, 8'h00, 0, 1'b0, 0);
      queue_read(10, 8);

      // random: mostly well-formed glyph columns and plots with read-back
      counted_items = 0;
      while (counted_items < 550) begin
         int pick;
         int col;
         int row;
         pick = $urandom_range(99);
         if (pick < 40) begin
            queue_glyph_column();
         end else if (pick < 65) begin
            col = $urandom_range(COLS - 1);
            row = $urandom_range(ROWS - 1);
            queue_request(ACT_PLOT, col, row, 2'($urandom), 8'($urandom), $urandom_range(7),
                          1'($urandom), $urandom_range(63));
            queue_read(col, row);
         end else if (pick < 80) begin
            queue_read($urandom_range(COLS - 1), $urandom_range(ROWS - 1));
         end else if (pick < 99) begin
            queue_noise();
         end else begin
            queue_request(ACT_CLEAR, $urandom_range(127), $urandom_range(63), 2'($urandom),
                          8'($urandom), $urandom_range(7), 1'($urandom), $urandom_range(63));
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // drain: everything accepted and every read answered
      do @(negedge clock);
      while (accepted_count < queued_count || expected_reads.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_reads.size() != 0)
         report_mismatch($sformatf("%0d reads never answered", expected_reads.size()));

      if (mismatch_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
